// ===== rtl/core/xrv_pkg.sv =====
package xrv_pkg;

   // Field widths of the channels
   localparam int CP_W      = 21;
   localparam int LEN_OUT_W = 16;
   localparam int STATUS_W  = 3;

   // Length counter width default, allowed range 4 to 32
   localparam int LENGTH_BITS_DEFAULT = 16;

   // Grammar characters
   localparam logic [CP_W-1:0] CP_AMP  = 21'h00_0026;
   localparam logic [CP_W-1:0] CP_HASH = 21'h00_0023;
   localparam logic [CP_W-1:0] CP_X    = 21'h00_0078;
   localparam logic [CP_W-1:0] CP_SEMI = 21'h00_003B;
   localparam logic [CP_W-1:0] MAX_CP  = 21'h10_FFFF;

   // Accumulator with room for one more hex digit
   localparam int ACC_EXT_W = CP_W + 4;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_AMP    = 5'b00010,
      PH_HASH   = 5'b00100,
      PH_DIGITS = 5'b01000,
      PH_NAME   = 5'b10000
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PENDING = 3'd0,
      ST_ENTITY  = 3'd1,
      ST_CHARREF = 3'd2,
      ST_INVALID = 3'd3,
      ST_IGNORED = 3'd4
   } status_type;

   typedef struct packed {
      logic       is_amp;
      logic       is_hash;
      logic       is_x;
      logic       is_semi;
      logic       name_start;
      logic       name_char;
      logic       dec_digit;
      logic       hex_letter;
      logic [3:0] digit_val;
   } char_class_type;

   typedef struct packed {
      status_type            status;
      logic [LEN_OUT_W-1:0]  consumed_length;
      logic [CP_W-1:0]       decoded_value;
   } result_type;

   function automatic logic in_rng(logic [CP_W-1:0] c, logic [CP_W-1:0] lo,
                                   logic [CP_W-1:0] hi);
      return (c >= lo) && (c <= hi);
   endfunction

   function automatic logic xml_char(logic [CP_W-1:0] c);
      return (c == 21'h9) || (c == 21'hA) || (c == 21'hD) ||
             in_rng(c, 21'h20, 21'hD7FF) || in_rng(c, 21'hE000, 21'hFFFD) ||
             in_rng(c, 21'h10000, 21'h10FFFF);
   endfunction

   function automatic logic name_start(logic [CP_W-1:0] c);
      return (c == 21'h3A) || (c == 21'h5F) ||
             in_rng(c, 21'h41, 21'h5A) || in_rng(c, 21'h61, 21'h7A) ||
             in_rng(c, 21'hC0, 21'hD6) || in_rng(c, 21'hD8, 21'hF6) ||
             in_rng(c, 21'hF8, 21'h2FF) || in_rng(c, 21'h370, 21'h37D) ||
             in_rng(c, 21'h37F, 21'h1FFF) || in_rng(c, 21'h200C, 21'h200D) ||
             in_rng(c, 21'h2070, 21'h218F) || in_rng(c, 21'h2C00, 21'h2FEF) ||
             in_rng(c, 21'h3001, 21'hD7FF) || in_rng(c, 21'hF900, 21'hFDCF) ||
             in_rng(c, 21'hFDF0, 21'hFFFD) || in_rng(c, 21'h10000, 21'hEFFFF);
   endfunction

   function automatic logic name_char(logic [CP_W-1:0] c);
      return name_start(c) || (c == 21'h2D) || (c == 21'h2E) ||
             in_rng(c, 21'h30, 21'h39) || (c == 21'hB7) ||
             in_rng(c, 21'h300, 21'h36F) || in_rng(c, 21'h203F, 21'h2040);
   endfunction

endpackage

// ===== rtl/core/xrv_req_if.sv =====
interface xrv_req_if
   import xrv_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            first_char;
   logic            last_char;

   modport source (output valid, code_point, first_char, last_char, input ready);
   modport sink   (input valid, code_point, first_char, last_char, output ready);
endinterface

// ===== rtl/core/xrv_rsp_if.sv =====
interface xrv_rsp_if
   import xrv_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [LEN_OUT_W-1:0] consumed_length;
   logic [CP_W-1:0]      decoded_value;

   modport source (output valid, status, consumed_length, decoded_value, input ready);
   modport sink   (input valid, status, consumed_length, decoded_value, output ready);
endinterface

// ===== rtl/core/xrv_char_class.sv =====
module xrv_char_class
   import xrv_pkg::*;
(
   input  logic [CP_W-1:0] code_point,
   output char_class_type  cls
);

   logic upper_hex;
   logic lower_hex;

   // Classify one code point against the reference grammar
   always_comb begin
      upper_hex      = in_rng(code_point, 21'h41, 21'h46);
      lower_hex      = in_rng(code_point, 21'h61, 21'h66);
      cls.is_amp     = (code_point == CP_AMP);
      cls.is_hash    = (code_point == CP_HASH);
      cls.is_x       = (code_point == CP_X);
      cls.is_semi    = (code_point == CP_SEMI);
      cls.name_start = name_start(code_point);
      cls.name_char  = name_char(code_point);
      cls.dec_digit  = in_rng(code_point, 21'h30, 21'h39);
      cls.hex_letter = upper_hex || lower_hex;
      // digits sit at low nibble 0..9, letters at 1..6 and map to 10..15
      if (cls.hex_letter) begin
         cls.digit_val = 4'(code_point[3:0] + 4'd9);
      end else begin
         cls.digit_val = code_point[3:0];
      end
   end

endmodule

// ===== rtl/core/xrv_parse_unit.sv =====
module xrv_parse_unit
   import xrv_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [CP_W-1:0] code_point,
   input  logic            first_char,
   input  logic            last_char,
   output result_type      result
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   char_class_type          cls;

   phase_type               phase_ff, phase_in;
   logic                    hex_ff, hex_in;
   logic                    digit_seen_ff, digit_seen_in;
   logic [CP_W-1:0]         acc_ff, acc_in;
   logic [LENGTH_BITS-1:0]  len_ff, len_in;

   status_type              status;
   logic                    digit_ok;
   logic [ACC_EXT_W-1:0]    acc_ext;
   logic [ACC_EXT_W-1:0]    acc_next;

   xrv_char_class u_class (
      .code_point (code_point),
      .cls        (cls)
   );

   // Scale the accumulator by the radix and add the digit
   always_comb begin
      acc_ext  = ACC_EXT_W'(acc_ff);
      if (hex_ff) begin
         acc_next = (acc_ext << 4) + ACC_EXT_W'(cls.digit_val);
      end else begin
         acc_next = (acc_ext << 3) + (acc_ext << 1) + ACC_EXT_W'(cls.digit_val);
      end
      digit_ok = cls.dec_digit || (hex_ff && cls.hex_letter);
   end

   // Step the parser for one item
   always_comb begin
      phase_in      = phase_ff;
      hex_in        = hex_ff;
      digit_seen_in = digit_seen_ff;
      acc_in        = acc_ff;
      len_in        = len_ff;
      status        = ST_PENDING;

      if (first_char) begin
         hex_in        = 1'b0;
         digit_seen_in = 1'b0;
         acc_in        = '0;
         len_in        = LENGTH_BITS'(1);
         if (cls.is_amp) begin
            phase_in = PH_AMP;
         end else begin
            phase_in = PH_IDLE;
            status   = ST_INVALID;
         end
      end else if (phase_ff == PH_IDLE) begin
         status = ST_IGNORED;
      end else begin
         if (len_ff != LEN_MAX) begin
            len_in = len_ff + LENGTH_BITS'(1);
         end
         case (phase_ff)
            PH_AMP: begin
               if (cls.is_hash) begin
                  phase_in = PH_HASH;
               end else if (cls.name_start) begin
                  phase_in = PH_NAME;
               end else begin
                  status = ST_INVALID;
               end
            end
            PH_NAME: begin
               if (cls.is_semi) begin
                  status = ST_ENTITY;
               end else if (!cls.name_char) begin
                  status = ST_INVALID;
               end
            end
            PH_HASH, PH_DIGITS: begin
               phase_in = PH_DIGITS;
               if ((phase_ff == PH_HASH) && cls.is_x) begin
                  hex_in = 1'b1;
               end else if (cls.is_semi) begin
                  status = (digit_seen_ff && xml_char(acc_ff)) ? ST_CHARREF : ST_INVALID;
               end else if (!digit_ok) begin
                  status = ST_INVALID;
               end else if (acc_next > ACC_EXT_W'(MAX_CP)) begin
                  status = ST_INVALID;
               end else begin
                  acc_in        = acc_next[CP_W-1:0];
                  digit_seen_in = 1'b1;
               end
            end
            default: begin
               status = ST_INVALID;
            end
         endcase
      end

      // End of text with the candidate still open
      if ((status == ST_PENDING) && last_char) begin
         status = ST_INVALID;
      end

      result.status          = status;
      result.consumed_length = LEN_OUT_W'(len_in);
      result.decoded_value   = ((phase_in == PH_HASH) || (phase_in == PH_DIGITS)) ?
                               acc_in : '0;
   end

   // Commit the state; any final status returns to idle
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hex_ff        <= 1'b0;
         digit_seen_ff <= 1'b0;
         acc_ff        <= '0;
         len_ff        <= '0;
      end else if (advance) begin
         if (status != ST_PENDING) begin
            phase_ff      <= PH_IDLE;
            hex_ff        <= 1'b0;
            digit_seen_ff <= 1'b0;
            acc_ff        <= '0;
            len_ff        <= '0;
         end else begin
            phase_ff      <= phase_in;
            hex_ff        <= hex_in;
            digit_seen_ff <= digit_seen_in;
            acc_ff        <= acc_in;
            len_ff        <= len_in;
         end
      end
   end

   // Digits and hex mode exist only inside a character reference
   a_digit_phase: assert property (@(posedge clock) disable iff (reset)
      (digit_seen_ff || hex_ff) |-> (phase_ff == PH_DIGITS))
      else $error("digit state outside character reference");

   // Accumulator stays inside the code point range
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= MAX_CP)
      else $error("accumulator above code point range");

   // Accumulator is nonzero only once a digit was taken
   a_acc_digit: assert property (@(posedge clock) disable iff (reset)
      (acc_ff != '0) |-> digit_seen_ff)
      else $error("accumulator set without a digit");

   // Idle means nothing counted
   a_idle_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (len_ff == '0))
      else $error("length counted while idle");

   // A final result always leaves the parser idle
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && (status != ST_PENDING)) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after final result");

endmodule

// ===== rtl/core/xml_reference_validator_core.sv =====
// Channel  Role    Payload
// req_ch   sink    code_point[20:0], first_char, last_char
// rsp_ch   source  status[2:0], consumed_length[15:0], decoded_value[20:0]
//
// Every accepted item yields exactly one result item, one item per cycle
// unless rsp_ch stalls. Items pass an input register, then the parse step
// into the result register, updated in the same cycle as the parser state.
// Reset is synchronous and leaves the parser idle with both stages empty.
// A stalled result holds the result register; the input register refills as
// soon as its item moves on, so a new item is taken in the cycle rsp_ch drains.
module xml_reference_validator_core
   import xrv_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   xrv_req_if.sink    req_ch,
   xrv_rsp_if.source  rsp_ch
);

   logic            s1_valid_ff;
   logic [CP_W-1:0] s1_code_point_ff;
   logic            s1_first_ff;
   logic            s1_last_ff;

   logic            rsp_valid_ff;
   result_type      rsp_ff;

   logic            out_free;
   logic            advance;
   logic            accept;
   result_type      step_result;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   // Capture the incoming item
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_code_point_ff <= req_ch.code_point;
         s1_first_ff      <= req_ch.first_char;
         s1_last_ff       <= req_ch.last_char;
      end
   end

   xrv_parse_unit #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .code_point (s1_code_point_ff),
      .first_char (s1_first_ff),
      .last_char  (s1_last_ff),
      .result     (step_result)
   );

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_ff.status;
   assign rsp_ch.consumed_length = rsp_ff.consumed_length;
   assign rsp_ch.decoded_value   = rsp_ff.decoded_value;

endmodule
